// ===== rtl/core/fmf_pkg.sv =====
// Shared types, constants and helper functions of the four-neighbor mean filter.
`timescale 1ns / 1ps

package fmf_pkg;

   // Configuration register widths and indexes.
   localparam int CFG_ROWS_W = 13;
   localparam int CFG_COLS_W = 11;
   localparam int CSR_IDX_W  = 4;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COLS = CSR_IDX_W'(1);

   // Reset values of the registers and default sizes.
   localparam int RST_FRAME_ROWS = 640;
   localparam int RST_FRAME_COLS = 480;
   localparam int DEF_MAX_COLS   = 1024;
   localparam int DEF_MAX_ROWS   = 4096;

   // Field widths of the result word.
   localparam int OUT_ROW_W = 12;
   localparam int OUT_COL_W = 10;
   localparam int CHAN_W    = 8;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pix_type;

   // One line store entry: the row before the previous one, then the previous row.
   typedef struct packed {
      pix_type older;
      pix_type newer;
   } line_pair_type;

   typedef struct packed {
      logic [CHAN_W-1:0] in_red;
      logic [CHAN_W-1:0] in_green;
      logic [CHAN_W-1:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]    out_red;
      logic [CHAN_W-1:0]    out_green;
      logic [CHAN_W-1:0]    out_blue;
      logic [OUT_ROW_W-1:0] out_row;
      logic [OUT_COL_W-1:0] out_col;
      logic                 frame_last;
   } rsp_type;

   // Truncated mean of four pixels, channel by channel.
   function automatic pix_type mean4(pix_type a, pix_type b, pix_type c, pix_type d);
      logic [CHAN_W+1:0] sum_r;
      logic [CHAN_W+1:0] sum_g;
      logic [CHAN_W+1:0] sum_b;
      pix_type           res;
      sum_r = (CHAN_W+2)'(a.red) + (CHAN_W+2)'(b.red) + (CHAN_W+2)'(c.red)
            + (CHAN_W+2)'(d.red);
      sum_g = (CHAN_W+2)'(a.green) + (CHAN_W+2)'(b.green) + (CHAN_W+2)'(c.green)
            + (CHAN_W+2)'(d.green);
      sum_b = (CHAN_W+2)'(a.blue) + (CHAN_W+2)'(b.blue) + (CHAN_W+2)'(c.blue)
            + (CHAN_W+2)'(d.blue);
      res.red   = sum_r[CHAN_W+1:2];
      res.green = sum_g[CHAN_W+1:2];
      res.blue  = sum_b[CHAN_W+1:2];
      return res;
   endfunction

   // Index of the last row or column once the size is held to 1..limit.
   function automatic int last_index(int size, int limit);
      int res;
      if (size < 1) begin
         res = 0;
      end else if (size > limit) begin
         res = limit - 1;
      end else begin
         res = size - 1;
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/fmf_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps

module fmf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // A read in the same cycle as a write to that address returns the old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== rtl/core/four_neighbor_mean_filter_top.sv =====
// Four-neighbor mean filter over an RGB raster stream, with its line store and output buffer.
`timescale 1ns / 1ps

// Pixels enter in raster order and each one past row 0 produces the filtered pixel one row up
// at the same column (the mean of its up, down, left and right neighbors, per channel,
// truncated; border pixels pass through), plus, on the last row, the incoming pixel itself.
// One pixel is taken per cycle while it yields at most one word and the output is not
// stalled; a last-row pixel yields two words and the stream waits, as the two-entry output
// buffer drains one word per cycle. The line store read is registered with the pixel, its
// words then in the output buffer. Both previous rows sit in one dual-read line store of
// MAX_COLS entries; it needs no clearing after reset. Writing either size register
// restarts the frame at row 0, column 0, and must happen only while the block is idle.

module four_neighbor_mean_filter_top #(
   parameter int MAX_COLS = fmf_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = fmf_pkg::DEF_MAX_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  fmf_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output fmf_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fmf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fmf_pkg::CFG_ROWS_W-1:0]   csr_wdata
);

   import fmf_pkg::*;

   localparam int ADDR_W = $clog2(MAX_COLS);
   localparam int ROW_W  = CFG_ROWS_W;

   // Handshakes.
   logic accept;
   logic csr_accept;
   logic pop;

   // Frame size and position.
   logic [ROW_W-1:0]  last_row_idx_ff, last_row_idx_in;
   logic [ADDR_W-1:0] last_col_idx_ff, last_col_idx_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ADDR_W-1:0] col_next;
   logic              at_last_row;
   logic              at_last_col;
   logic              restart;

   // Compute stage.
   logic              s1_valid_ff, s1_valid_in;
   pix_type           s1_pix_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [ADDR_W-1:0] s1_col_ff;
   logic              s1_last_row_ff;
   logic              s1_last_col_ff;
   logic              s1_fwd_c_ff;
   logic              s1_fwd_r_ff;
   pix_type           s1_fwd_newer_ff;
   pix_type           s1_fwd_older_ff;
   logic              s1_fire;
   pix_type           left_hold_ff;

   // Line store.
   line_pair_type     rd_here;
   line_pair_type     rd_right;
   line_pair_type     wr_pair;
   pix_type           centre;
   pix_type           up;
   pix_type           right;
   pix_type           filtered;
   logic              border;

   // Output buffer.
   rsp_type           res_a;
   rsp_type           res_b;
   rsp_type           new0;
   logic              has_a;
   logic              has_b;
   logic [1:0]        n_new;
   logic [1:0]        remain;
   rsp_type           q0_ff, q0_in;
   rsp_type           q1_ff, q1_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [OUT_COL_W+ADDR_W-1:0] col_ext;
   logic [ROW_W-1:0]  out_row_up;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign accept     = req_valid && req_ready;
   assign rsp_valid  = (cnt_ff != 2'd0);
   assign rsp_payload = q0_ff;
   assign pop        = rsp_valid && rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_fire;

   // Size registers, held as the index of the last row and column.
   always_comb begin
      last_row_idx_in = last_row_idx_ff;
      last_col_idx_in = last_col_idx_ff;
      restart         = 1'b0;
      if (csr_accept) begin
         unique case (csr_index)
            REG_FRAME_ROWS: begin
               last_row_idx_in = ROW_W'(last_index(int'(csr_wdata[CFG_ROWS_W-1:0]), MAX_ROWS));
               restart         = 1'b1;
            end
            REG_FRAME_COLS: begin
               last_col_idx_in = ADDR_W'(last_index(int'(csr_wdata[CFG_COLS_W-1:0]), MAX_COLS));
               restart         = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Position of the next pixel.
   assign at_last_row = (row_ff == last_row_idx_ff);
   assign at_last_col = (col_ff == last_col_idx_ff);
   assign col_next    = (col_ff == ADDR_W'(MAX_COLS - 1)) ? '0 : col_ff + 1'b1;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (at_last_col) begin
            col_in = '0;
            row_in = at_last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_row_idx_ff <= ROW_W'(last_index(RST_FRAME_ROWS, MAX_ROWS));
         last_col_idx_ff <= ADDR_W'(last_index(RST_FRAME_COLS, MAX_COLS));
         row_ff          <= '0;
         col_ff          <= '0;
      end else begin
         last_row_idx_ff <= last_row_idx_in;
         last_col_idx_ff <= last_col_idx_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
      end
   end

   // Line store: entry j holds rows i-2 and i-1 at column j.
   assign wr_pair.older = centre;
   assign wr_pair.newer = s1_pix_ff;

   fmf_ram #(
      .WIDTH ($bits(line_pair_type)),
      .DEPTH (MAX_COLS)
   ) u_line_ram (
      .clock     (clock),
      .wr_en     (s1_fire),
      .wr_addr   (s1_col_ff),
      .wr_data   (wr_pair),
      .rd_en     (accept),
      .rd_addr_a (col_ff),
      .rd_addr_b (col_next),
      .rd_data_a (rd_here),
      .rd_data_b (rd_right)
   );

   // Compute stage registers; a write in the accept cycle is forwarded past the RAM.
   assign s1_valid_in = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff.red   <= req_payload.in_red;
         s1_pix_ff.green <= req_payload.in_green;
         s1_pix_ff.blue  <= req_payload.in_blue;
         s1_row_ff       <= row_ff;
         s1_col_ff       <= col_ff;
         s1_last_row_ff  <= at_last_row;
         s1_last_col_ff  <= at_last_col;
         s1_fwd_c_ff     <= s1_fire && (s1_col_ff == col_ff);
         s1_fwd_r_ff     <= s1_fire && (s1_col_ff == col_next);
         s1_fwd_newer_ff <= s1_pix_ff;
         s1_fwd_older_ff <= centre;
      end
      if (s1_fire) begin
         left_hold_ff <= centre;
      end
   end

   // Neighbors and the filtered value of the pixel one row up.
   assign centre   = s1_fwd_c_ff ? s1_fwd_newer_ff : rd_here.newer;
   assign up       = s1_fwd_c_ff ? s1_fwd_older_ff : rd_here.older;
   assign right    = s1_fwd_r_ff ? s1_fwd_newer_ff : rd_right.newer;
   assign filtered = mean4(up, s1_pix_ff, left_hold_ff, right);
   assign border   = (s1_row_ff == ROW_W'(1)) || (s1_col_ff == '0) || s1_last_col_ff;

   assign col_ext    = {{OUT_COL_W{1'b0}}, s1_col_ff};
   assign out_row_up = s1_row_ff - 1'b1;

   always_comb begin
      res_a.out_red    = border ? centre.red   : filtered.red;
      res_a.out_green  = border ? centre.green : filtered.green;
      res_a.out_blue   = border ? centre.blue  : filtered.blue;
      res_a.out_row    = out_row_up[OUT_ROW_W-1:0];
      res_a.out_col    = col_ext[OUT_COL_W-1:0];
      res_a.frame_last = 1'b0;
      res_b.out_red    = s1_pix_ff.red;
      res_b.out_green  = s1_pix_ff.green;
      res_b.out_blue   = s1_pix_ff.blue;
      res_b.out_row    = s1_row_ff[OUT_ROW_W-1:0];
      res_b.out_col    = col_ext[OUT_COL_W-1:0];
      res_b.frame_last = s1_last_col_ff;
   end

   // Output buffer: the stage fires when all its words fit after this cycle's pop.
   assign has_a  = (s1_row_ff != '0);
   assign has_b  = s1_last_row_ff;
   assign n_new  = {1'b0, has_a} + {1'b0, has_b};
   assign new0   = has_a ? res_a : res_b;
   assign remain = cnt_ff - {1'b0, pop};
   assign s1_fire = s1_valid_ff && ((3'(remain) + 3'(n_new)) <= 3'd2);

   always_comb begin
      q0_in = q0_ff;
      q1_in = q1_ff;
      if (pop) begin
         q0_in = q1_ff;
      end
      if (s1_fire) begin
         if (remain == 2'd0) begin
            q0_in = new0;
            q1_in = res_b;
         end else if (remain == 2'd1) begin
            q1_in = new0;
         end
      end
      cnt_in = remain + (s1_fire ? n_new : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   // The output buffer never holds more than its two entries.
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("output buffer count out of range");

   // A pixel that yields two words leaves the buffer full.
   assert property (@(posedge clock) disable iff (reset)
      s1_fire && has_a && has_b |=> cnt_ff == 2'd2)
      else $error("two-word pixel did not fill the output buffer");

   // Centre and right neighbor are never forwarded from the same write.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !(s1_fwd_c_ff && s1_fwd_r_ff))
      else $error("forwarding hit two columns at once");

   // A stalled compute stage keeps its pixel position.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_col_ff) && $stable(s1_row_ff))
      else $error("compute stage changed while stalled");

endmodule
